@@ design/c2p_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// c2p_pkg: shared constants and functions
// Widths, fixed-point scales, arctangent table and gain computation for the
// pipelined CORDIC Cartesian-to-polar converter.
// ----------------------------------------------------------------------------
package c2p_pkg;

	localparam int COORD_W        = 24;
	localparam int RAD_W          = 24;
	localparam int AZ_W           = 16;
	localparam int S_TDATA_W      = 48;
	localparam int M_TDATA_W      = 40;
	localparam int FRAC_W         = 30;  // datapath scale 2^30
	localparam int DP_W           = 57;  // holds |x|*2^30 times CORDIC growth
	localparam int ANG_W          = 35;  // angle in 2^-30 rad, up to about 2*pi
	localparam int K_W            = 30;  // gain compensation, Q30, below 1.0
	localparam int XR_SHIFT       = 21;  // final x rounded to 2^-9 LSB
	localparam int PROD_SHIFT     = 39;  // 2^-9 * Q30 back to whole LSB
	localparam int AZ_SHIFT       = 17;  // 2^-30 rad to Q2.13
	localparam int MAX_ITER       = 32;
	localparam int ITERATIONS_DEF = 16;

	localparam logic signed [ANG_W-1:0] ANG_PI     = 35'sd3373259426;
	localparam logic signed [AZ_W-1:0]  AZ_PI      = 16'sd25736;
	localparam logic signed [AZ_W-1:0]  AZ_HALF_PI = 16'sd12868;

	// atan(2^-i) in 2^-30 rad, truncated
	localparam logic [31:0] ATAN_TAB [MAX_ITER] = '{
		32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6,
		32'h03FEAB76, 32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55,
		32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
		32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF,
		32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
		32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
		32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008,
		32'h00000004, 32'h00000002, 32'h00000001, 32'h00000000
	};

	function automatic logic [63:0] isqrt64(logic [63:0] v_in);
		logic [63:0] v;
		logic [63:0] res;
		logic [63:0] bw;
		v   = v_in;
		res = '0;
		bw  = 64'(1) << 62;
		for (int k = 0; k < 32; k++) begin
			if (v >= res + bw) begin
				v   = v - (res + bw);
				res = (res >> 1) + bw;
			end else begin
				res = res >> 1;
			end
			bw = bw >> 2;
		end
		return res;
	endfunction

	// 1/sqrt(prod(1 + 4^-i)) in Q30, evaluated at elaboration
	function automatic logic [63:0] gain_q30(int n);
		logic [127:0] p;
		logic [63:0]  f;
		logic [63:0]  s;
		logic [63:0]  num;
		logic [63:0]  q;
		logic [64:0]  rem;
		p = 128'(1) << 30;
		for (int i = 0; i < MAX_ITER; i++) begin
			if (i < n) begin
				f = 64'(1) << 30;
				if (2 * i <= 30) begin
					f = f + (64'(1) << (30 - 2 * i));
				end
				p = (p * {64'b0, f} + (128'(1) << 29)) >> 30;
			end
		end
		s = isqrt64(p[63:0] << 30);
		if (s == '0) begin
			s = 64'd1;
		end
		num = (64'(1) << 60) + (s >> 1);
		rem = '0;
		q   = '0;
		for (int b = 63; b >= 0; b--) begin
			rem = {rem[63:0], num[b]};
			if (rem >= {1'b0, s}) begin
				rem  = rem - {1'b0, s};
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

endpackage
`default_nettype wire

@@ design/cartesian_to_polar_converter.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cartesian_to_polar_converter: pipelined CORDIC vectoring converter
//
// Input stream (s_*): one word per point, x and y in signed Q15.8.
// Output stream (m_*): one word per point, radius (unsigned Q16.8, gain
// compensated) and azimuth atan2(y, x) in radians, Q2.13, both rounded.
// Points on an axis skip the rotations and take exact values.
//
// The pipeline is a pre-rotation stage that folds the left half plane over
// by pi, one register stage per micro-rotation, a stage for the split gain
// multiply, and the rounding/saturation output register.
// Throughput is one word per cycle while the receiver keeps m_tready high.
// Each stage holds a valid bit and moves when the stage after it is empty
// or moving, so a stalled receiver only stops the stages behind the held
// result; bubbles still fill and s_tready stays high until the pipe is full.
// Reset clears all valid bits; nothing is lost or repeated across a stall.
// ----------------------------------------------------------------------------
module cartesian_to_polar_converter #(
	parameter int ITERATIONS = c2p_pkg::ITERATIONS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [c2p_pkg::S_TDATA_W-1:0]  s_tdata,   // x_coord[23:0], y_coord[47:24]
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [c2p_pkg::M_TDATA_W-1:0]  m_tdata    // radius[23:0], azimuth[39:24]
);

	import c2p_pkg::*;

	localparam int N          = (ITERATIONS > MAX_ITER) ? MAX_ITER : ITERATIONS;
	localparam int T          = N + 3;
	localparam int XR_W       = DP_W - XR_SHIFT;
	localparam int XL_W       = 17;
	localparam int XH_W       = XR_W - XL_W;
	localparam int PH_W       = XH_W + K_W;
	localparam int PL_W       = XL_W + K_W;
	localparam int PS_W       = PH_W + XL_W + 1;
	localparam int RF_W       = PS_W - PROD_SHIFT;
	localparam int AZF_W      = ANG_W - AZ_SHIFT;
	localparam logic [K_W-1:0] GAIN = K_W'(gain_q30(N));

	// ---------------- stage handshake ----------------
	logic [T-1:0] vld_s;
	logic [T:0]   adv;
	logic [T-1:0] vld_in;

	assign adv[T]   = m_tready;
	assign vld_in   = {vld_s[T-2:0], s_tvalid};
	assign s_tready = adv[0];
	assign m_tvalid = vld_s[T-1];

	for (genvar k = 0; k < T; k++) begin : g_adv
		assign adv[k] = !vld_s[k] || adv[k+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			for (int k = 0; k < T; k++) begin
				if (adv[k]) begin
					vld_s[k] <= vld_in[k];
				end
			end
		end
	end

	// ---------------- pre-rotation ----------------
	logic signed [COORD_W-1:0] x_in, y_in;
	logic signed [COORD_W:0]   xe, ye, cx0, cy0, absy;
	logic signed [ANG_W-1:0]   z0;
	logic                      byp0;
	logic [RAD_W-1:0]          brad0;
	logic signed [AZ_W-1:0]    baz0;

	assign x_in = signed'(s_tdata[COORD_W-1:0]);
	assign y_in = signed'(s_tdata[2*COORD_W-1:COORD_W]);
	assign xe   = {x_in[COORD_W-1], x_in};
	assign ye   = {y_in[COORD_W-1], y_in};

	always_comb begin
		cx0  = x_in[COORD_W-1] ? -xe : xe;
		cy0  = x_in[COORD_W-1] ? -ye : ye;
		absy = y_in[COORD_W-1] ? -ye : ye;
		z0   = '0;
		if (x_in[COORD_W-1]) begin
			z0 = y_in[COORD_W-1] ? -ANG_PI : ANG_PI;
		end
		byp0 = (y_in == '0) || (x_in == '0);
		if (y_in == '0) begin
			brad0 = cx0[RAD_W-1:0];
			baz0  = x_in[COORD_W-1] ? AZ_PI : '0;
		end else begin
			brad0 = absy[RAD_W-1:0];
			baz0  = y_in[COORD_W-1] ? -AZ_HALF_PI : AZ_HALF_PI;
		end
	end

	logic signed [DP_W-1:0]  cx_s [0:N];
	logic signed [DP_W-1:0]  cy_s [0:N];
	logic signed [ANG_W-1:0] z_s  [0:N];
	logic                    byp_s  [0:N+1];
	logic [RAD_W-1:0]        brad_s [0:N+1];
	logic signed [AZ_W-1:0]  baz_s  [0:N+1];

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			cx_s[0]   <= {{(DP_W-COORD_W-1-FRAC_W){cx0[COORD_W]}}, cx0, {FRAC_W{1'b0}}};
			cy_s[0]   <= {{(DP_W-COORD_W-1-FRAC_W){cy0[COORD_W]}}, cy0, {FRAC_W{1'b0}}};
			z_s[0]    <= z0;
			byp_s[0]  <= byp0;
			brad_s[0] <= brad0;
			baz_s[0]  <= baz0;
		end
	end

	// ---------------- micro-rotations, one per stage ----------------
	for (genvar i = 0; i < N; i++) begin : g_rot
		logic signed [DP_W-1:0]  dx, dy;
		logic signed [ANG_W-1:0] da;

		assign dx = cy_s[i] >>> i;
		assign dy = cx_s[i] >>> i;
		assign da = signed'({{(ANG_W-32){1'b0}}, ATAN_TAB[i]});

		always_ff @(posedge clk) begin
			if (adv[i+1]) begin
				if (!cy_s[i][DP_W-1]) begin
					cx_s[i+1] <= cx_s[i] + dx;
					cy_s[i+1] <= cy_s[i] - dy;
					z_s[i+1]  <= z_s[i] + da;
				end else begin
					cx_s[i+1] <= cx_s[i] - dx;
					cy_s[i+1] <= cy_s[i] + dy;
					z_s[i+1]  <= z_s[i] - da;
				end
				byp_s[i+1]  <= byp_s[i];
				brad_s[i+1] <= brad_s[i];
				baz_s[i+1]  <= baz_s[i];
			end
		end
	end

	// ---------------- gain multiply, split in two partial products ----------------
	logic [DP_W-1:0]         cx_pos, xr_sum;
	logic [XR_W-1:0]         xr;
	logic [PH_W-1:0]         phi_d;
	logic [PL_W-1:0]         plo_d;
	logic signed [ANG_W-1:0] azr;

	assign cx_pos = cx_s[N][DP_W-1] ? '0 : unsigned'(cx_s[N]);
	assign xr_sum = cx_pos + (DP_W'(1) << (XR_SHIFT - 1));
	assign xr     = xr_sum[DP_W-1:XR_SHIFT];
	assign phi_d  = {{K_W{1'b0}}, xr[XR_W-1:XL_W]} * {{XH_W{1'b0}}, GAIN};
	assign plo_d  = {{K_W{1'b0}}, xr[XL_W-1:0]} * {{XL_W{1'b0}}, GAIN};
	assign azr    = z_s[N] + (ANG_W'(1) <<< (AZ_SHIFT - 1));

	logic [PH_W-1:0]         phi_smul;
	logic [PL_W-1:0]         plo_smul;
	logic signed [AZF_W-1:0] az_smul;

	always_ff @(posedge clk) begin
		if (adv[N+1]) begin
			phi_smul      <= phi_d;
			plo_smul      <= plo_d;
			az_smul       <= azr[ANG_W-1:AZ_SHIFT];
			byp_s[N+1]    <= byp_s[N];
			brad_s[N+1]   <= brad_s[N];
			baz_s[N+1]    <= baz_s[N];
		end
	end

	// ---------------- rounding, saturation, output register ----------------
	logic [PS_W-1:0]         psum;
	logic [RF_W-1:0]         rad_full;
	logic [RAD_W-1:0]        rad_d;
	logic signed [AZ_W-1:0]  az_d;

	assign psum     = {1'b0, phi_smul, {XL_W{1'b0}}} + {{(PS_W-PL_W){1'b0}}, plo_smul}
	                  + (PS_W'(1) << (PROD_SHIFT - 1));
	assign rad_full = psum[PS_W-1:PROD_SHIFT];

	always_comb begin
		if (byp_s[N+1]) begin
			rad_d = brad_s[N+1];
			az_d  = baz_s[N+1];
		end else begin
			if (rad_full > RF_W'({RAD_W{1'b1}})) begin
				rad_d = '1;
			end else begin
				rad_d = rad_full[RAD_W-1:0];
			end
			if (az_smul > AZF_W'(AZ_PI)) begin
				az_d = AZ_PI;
			end else if (az_smul < -AZF_W'(AZ_PI)) begin
				az_d = -AZ_PI;
			end else begin
				az_d = az_smul[AZ_W-1:0];
			end
		end
	end

	logic [RAD_W-1:0]       radius_sout;
	logic signed [AZ_W-1:0] azimuth_sout;

	always_ff @(posedge clk) begin
		if (adv[N+2]) begin
			radius_sout  <= rad_d;
			azimuth_sout <= az_d;
		end
	end

	assign m_tdata = {azimuth_sout, radius_sout};

	// ---------------- assertions ----------------
	a_az_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (signed'(m_tdata[RAD_W+AZ_W-1:RAD_W]) <= AZ_PI &&
		              signed'(m_tdata[RAD_W+AZ_W-1:RAD_W]) >= -AZ_PI))
		else $error("azimuth out of range");

	a_ready_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!vld_s[T-1] |-> s_tready)
		else $error("input stalled with empty output stage");

	a_out_from_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready) |=> (m_tvalid == $past(vld_s[T-2])))
		else $error("output valid not fed from previous stage");

endmodule
`default_nettype wire
